@@ rtl/mbba_pkg.sv @@
// shared types, constants and helpers for the bitmap block allocator
package mbba_pkg;

    // number of pages the allocator can bring into use (1 to 16)
    localparam int NUM_PAGES = 16;

    // geometry of one page
    localparam int BLOCK_BYTES     = 128;
    localparam int BLOCKS_PER_PAGE = 32;
    localparam int MAX_LENGTH      = 4096;
    localparam int BLOCK_SHIFT     = $clog2(BLOCK_BYTES);

    // field widths
    localparam int LEN_W    = 13;
    localparam int STATUS_W = 2;
    localparam int OUT_PG_W = 4;
    localparam int OFF_W    = $clog2(BLOCKS_PER_PAGE);
    localparam int BLK_W    = $clog2(BLOCKS_PER_PAGE + 1);

    // page index and page count widths
    localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CNT_W  = $clog2(NUM_PAGES + 1);

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_LENGTH = 2'd1,
        ST_NO_PAGE    = 2'd2
    } status_t;

    // decoded request handed from the front end to the sequencer
    typedef struct packed {
        logic                       bad;
        logic [BLOCKS_PER_PAGE-1:0] run;
        logic [OFF_W-1:0]           max_off;
    } req_t;

    // answer of the per-page fit check
    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] offset;
    } fit_t;

    // low bits of a page index as seen on the result port
    function automatic logic [OUT_PG_W-1:0] out_page(input logic [PAGE_W-1:0] p);
        logic [PAGE_W+OUT_PG_W-1:0] w;
        w = {{OUT_PG_W{1'b0}}, p};
        return w[OUT_PG_W-1:0];
    endfunction

endpackage

@@ rtl/mbba_fit.sv @@
// fit unit: tests all offsets of one page bitmap and picks the lowest free run
module mbba_fit (
    input  logic [mbba_pkg::BLOCKS_PER_PAGE-1:0] bitmap,
    input  logic [mbba_pkg::BLOCKS_PER_PAGE-1:0] run,
    input  logic [mbba_pkg::OFF_W-1:0]           max_off,
    output mbba_pkg::fit_t                       fit
);

    logic [mbba_pkg::BLOCKS_PER_PAGE-1:0] fits;

    // one free-run test per offset, all in parallel
    always_comb
    begin
        for (int j = 0; j < mbba_pkg::BLOCKS_PER_PAGE; j++)
        begin
            fits[j] = (mbba_pkg::OFF_W'(j) <= max_off) &&
                      ((bitmap & (run << j)) == '0);
        end
    end

    // lowest offset wins
    always_comb
    begin
        fit.found  = 1'b0;
        fit.offset = '0;
        for (int j = mbba_pkg::BLOCKS_PER_PAGE - 1; j >= 0; j--)
        begin
            if (fits[j])
            begin
                fit.found  = 1'b1;
                fit.offset = mbba_pkg::OFF_W'(j);
            end
        end
    end

endmodule

@@ rtl/mbba_seq.sv @@
// page walk sequencer with the bitmap memory and the result registers
module mbba_seq (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  mbba_pkg::req_t                     req,
    output logic                               busy,
    output logic                               done,
    output logic [mbba_pkg::STATUS_W-1:0]      status,
    output logic [mbba_pkg::OUT_PG_W-1:0]      page_index,
    output logic [mbba_pkg::OFF_W-1:0]         first_block,
    output logic                               page_added
);

    typedef enum logic {
        S_IDLE,
        S_CHECK
    } state_t;

    localparam int PW = mbba_pkg::PAGE_W;
    localparam int CW = mbba_pkg::CNT_W;
    localparam int BW = mbba_pkg::BLOCKS_PER_PAGE;

    state_t                     state_reg, state_next;
    logic [PW-1:0]              page_reg, page_next;
    logic [CW-1:0]              used_reg, used_next;
    logic [BW-1:0]              run_reg, run_next;
    logic [mbba_pkg::OFF_W-1:0] max_off_reg, max_off_next;

    logic                       done_reg, done_next;
    mbba_pkg::status_t          status_reg, status_next;
    logic [PW-1:0]              res_page_reg, res_page_next;
    logic [mbba_pkg::OFF_W-1:0] res_off_reg, res_off_next;
    logic                       added_reg, added_next;

    // bitmap memory; pages at or above the used count are never examined
    logic [BW-1:0]              mem [mbba_pkg::NUM_PAGES];
    logic [BW-1:0]              rd_data_reg;
    logic [PW-1:0]              rd_addr;
    logic                       wr_en;
    logic [PW-1:0]              wr_addr;
    logic [BW-1:0]              wr_data;

    mbba_pkg::fit_t             fit;
    logic                       last_page;
    logic                       pages_full;
    logic [PW-1:0]              spare_page;

    mbba_fit u_fit (
        .bitmap  (rd_data_reg),
        .run     (run_reg),
        .max_off (max_off_reg),
        .fit     (fit)
    );

    assign last_page  = (CW'(page_reg) + CW'(1)) == used_reg;
    assign pages_full = used_reg == CW'(mbba_pkg::NUM_PAGES);
    assign spare_page = used_reg[PW-1:0];

    // memory port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // next state, memory access and result
    always_comb
    begin
        state_next    = state_reg;
        page_next     = page_reg;
        used_next     = used_reg;
        run_next      = run_reg;
        max_off_next  = max_off_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        res_page_next = res_page_reg;
        res_off_next  = res_off_reg;
        added_next    = added_reg;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = spare_page;
        wr_data       = run_reg;

        case (state_reg)
            S_IDLE:
            begin
                rd_addr = '0;
                if (accept)
                begin
                    run_next     = req.run;
                    max_off_next = req.max_off;
                    page_next    = '0;
                    if (req.bad)
                    begin
                        done_next     = 1'b1;
                        status_next   = mbba_pkg::ST_BAD_LENGTH;
                        res_page_next = '0;
                        res_off_next  = '0;
                        added_next    = 1'b0;
                    end
                    else if (used_reg == '0)
                    begin
                        // nothing in use yet: open page zero
                        wr_en         = 1'b1;
                        wr_data       = req.run;
                        used_next     = CW'(1);
                        done_next     = 1'b1;
                        status_next   = mbba_pkg::ST_OK;
                        res_page_next = '0;
                        res_off_next  = '0;
                        added_next    = 1'b1;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                rd_addr = page_reg + PW'(1);
                if (fit.found)
                begin
                    // claim the run in this page
                    wr_en         = 1'b1;
                    wr_addr       = page_reg;
                    wr_data       = rd_data_reg | (run_reg << fit.offset);
                    done_next     = 1'b1;
                    status_next   = mbba_pkg::ST_OK;
                    res_page_next = page_reg;
                    res_off_next  = fit.offset;
                    added_next    = 1'b0;
                    state_next    = S_IDLE;
                end
                else if (last_page)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    res_off_next = '0;
                    if (!pages_full)
                    begin
                        // bring the next unused page into use
                        wr_en         = 1'b1;
                        wr_addr       = spare_page;
                        wr_data       = run_reg;
                        used_next     = used_reg + CW'(1);
                        status_next   = mbba_pkg::ST_OK;
                        res_page_next = spare_page;
                        added_next    = 1'b1;
                    end
                    else
                    begin
                        status_next   = mbba_pkg::ST_NO_PAGE;
                        res_page_next = '0;
                        added_next    = 1'b0;
                    end
                end
                else
                begin
                    page_next = page_reg + PW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            page_reg     <= '0;
            used_reg     <= '0;
            done_reg     <= 1'b0;
            status_reg   <= mbba_pkg::ST_OK;
            res_page_reg <= '0;
            res_off_reg  <= '0;
            added_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            page_reg     <= page_next;
            used_reg     <= used_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
            res_page_reg <= res_page_next;
            res_off_reg  <= res_off_next;
            added_reg    <= added_next;
        end
    end

    // request registers
    always_ff @(posedge clk)
    begin
        run_reg     <= run_next;
        max_off_reg <= max_off_next;
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign status       = status_reg;
    assign page_index   = mbba_pkg::out_page(res_page_reg);
    assign first_block  = res_off_reg;
    assign page_added   = added_reg;

    // used page count never runs past the page pool
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(mbba_pkg::NUM_PAGES))
        else $error("page count beyond pool");

    // the walk only visits pages that are in use
    a_walk_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> CW'(page_reg) < used_reg)
        else $error("walk reached an unused page");

    // a failed request reports all-zero location fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg != mbba_pkg::ST_OK |->
            res_page_reg == '0 && res_off_reg == '0 && !added_reg)
        else $error("failed request carries a location");

    // a new page grows the count by one and starts at offset zero
    a_new_page: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && added_reg |->
            used_reg == $past(used_reg) + CW'(1) && res_off_reg == '0)
        else $error("new page bookkeeping mismatch");

    // no result strobe while a page walk is still running
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result strobe during a walk");

endmodule

@@ rtl/mmio_block_bitmap_allocator.sv @@
// first-fit bitmap block allocator top level: length decode and sequencer
//
// A request is taken when start is high and busy is low. Its result appears on
// status, page_index, first_block and page_added, marked by done for exactly one
// cycle; the receiver cannot stall it, so it must be taken on that cycle. A
// rejected length, or the very first allocation, reports on the cycle after
// acceptance. Otherwise the sequencer reads one page bitmap a cycle from the
// bitmap memory and tests every offset of it at once in the fit unit. busy
// drops in the cycle that shows the result, and a new request may be given
// then. The bitmap of a page not yet in use is never examined, so the memory
// needs no clearing pass after reset.
module mmio_block_bitmap_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mbba_pkg::LEN_W-1:0]    length_bytes,
    output logic                          done,
    output logic [mbba_pkg::STATUS_W-1:0] status,
    output logic [mbba_pkg::OUT_PG_W-1:0] page_index,
    output logic [mbba_pkg::OFF_W-1:0]    first_block,
    output logic                          page_added
);

    localparam int BW = mbba_pkg::BLOCKS_PER_PAGE;

    logic                          accept;
    logic [mbba_pkg::LEN_W:0]      len_round;
    logic [mbba_pkg::BLK_W-1:0]    blocks;
    logic [BW:0]                   run_wide;
    logic [mbba_pkg::BLK_W-1:0]    off_room;
    mbba_pkg::req_t                req;

    assign accept = start && !busy;

    // round the length up to whole blocks and build the run mask
    always_comb
    begin
        len_round = {1'b0, length_bytes} + (mbba_pkg::LEN_W + 1)'(mbba_pkg::BLOCK_BYTES - 1);
        blocks    = mbba_pkg::BLK_W'(len_round >> mbba_pkg::BLOCK_SHIFT);
        run_wide  = ((BW + 1)'(1) << blocks) - (BW + 1)'(1);
        off_room  = mbba_pkg::BLK_W'(BW) - blocks;

        req.bad     = (length_bytes == '0) ||
                      (length_bytes > mbba_pkg::LEN_W'(mbba_pkg::MAX_LENGTH));
        req.run     = run_wide[BW-1:0];
        req.max_off = off_room[mbba_pkg::OFF_W-1:0];
    end

    mbba_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .req          (req),
        .busy         (busy),
        .done         (done),
        .status       (status),
        .page_index   (page_index),
        .first_block  (first_block),
        .page_added   (page_added)
    );

endmodule
